// ----- rtl/fuzzy_match_result_classifier_macros.svh -----
// ----------------------------------------------------------------------------
// Fuzzy match result classifier: assertion macros
// Forms for the concurrent checks of the classifier's grade queue.
// ----------------------------------------------------------------------------
`ifndef FUZZY_MATCH_RESULT_CLASSIFIER_MACROS_SVH
`define FUZZY_MATCH_RESULT_CLASSIFIER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define FMRC_ASSERT_NOW(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that, when seen, requires a consequence at the next clock edge.
`define FMRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ----- rtl/fmrc_pkg.sv -----
// ----------------------------------------------------------------------------
// Fuzzy match result classifier: package
// Grade formats, membership breakpoints with their reciprocals, class codes.
// ----------------------------------------------------------------------------
package fmrc_pkg;

	// Grades are Q0.12; 4096 is full membership, so one extra bit is needed.
	localparam int GRADE_FRAC = 12;
	localparam int GRADE_W    = GRADE_FRAC + 1;
	localparam logic [GRADE_W-1:0] GRADE_ONE = GRADE_W'(1 << GRADE_FRAC);

	// A ramp numerator never exceeds the widest segment (3604 codes).
	localparam int NUM_W = 12;

	// floor(num * 4096 / den) = (num * ceil(2^36 / den)) >> 24, exact for num <= den < 4096.
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 28;
	localparam longint unsigned RECIP_NUMER = 64'd1 << (GRADE_FRAC + RECIP_SHIFT);

	// Default number of words the grade queue holds.
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef logic [GRADE_W-1:0] grade_t;

	// The six membership grades of one word.
	typedef struct packed {
		grade_t c_low;
		grade_t c_med;
		grade_t c_high;
		grade_t d_short;
		grade_t d_med;
		grade_t d_long;
	} grades_t;

	// Breakpoints of one input: low p0/p1, medium p2/p3/p4, high p5/p6,
	// plus the reciprocal of each sloped segment.
	typedef struct packed {
		logic [15:0] p0;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [RECIP_W-1:0] r_low;
		logic [RECIP_W-1:0] r_mrise;
		logic [RECIP_W-1:0] r_mfall;
		logic [RECIP_W-1:0] r_high;
	} shape_t;

	// Confidence, Q2.14.
	localparam shape_t CONF_EASY = '{
		p0: 16'd9011, p1: 16'd10650, p2: 16'd9830, p3: 16'd11469, p4: 16'd13107,
		p5: 16'd12288, p6: 16'd14746,
		r_low:   RECIP_W'((RECIP_NUMER + 64'd1638) / 64'd1639),
		r_mrise: RECIP_W'((RECIP_NUMER + 64'd1638) / 64'd1639),
		r_mfall: RECIP_W'((RECIP_NUMER + 64'd1637) / 64'd1638),
		r_high:  RECIP_W'((RECIP_NUMER + 64'd2457) / 64'd2458)
	};
	localparam shape_t CONF_STRICT = '{
		p0: 16'd9011, p1: 16'd10650, p2: 16'd9830, p3: 16'd11469, p4: 16'd15073,
		p5: 16'd14336, p6: 16'd15565,
		r_low:   RECIP_W'((RECIP_NUMER + 64'd1638) / 64'd1639),
		r_mrise: RECIP_W'((RECIP_NUMER + 64'd1638) / 64'd1639),
		r_mfall: RECIP_W'((RECIP_NUMER + 64'd3603) / 64'd3604),
		r_high:  RECIP_W'((RECIP_NUMER + 64'd1228) / 64'd1229)
	};

	// Duration, Q8.8 seconds.
	localparam shape_t DUR_EASY = '{
		p0: 16'd384, p1: 16'd768, p2: 16'd512, p3: 16'd2560, p4: 16'd5632,
		p5: 16'd4480, p6: 16'd5120,
		r_low:   RECIP_W'((RECIP_NUMER + 64'd383) / 64'd384),
		r_mrise: RECIP_W'((RECIP_NUMER + 64'd2047) / 64'd2048),
		r_mfall: RECIP_W'((RECIP_NUMER + 64'd3071) / 64'd3072),
		r_high:  RECIP_W'((RECIP_NUMER + 64'd639) / 64'd640)
	};
	localparam shape_t DUR_STRICT = '{
		p0: 16'd512, p1: 16'd1280, p2: 16'd717, p3: 16'd3072, p4: 16'd4915,
		p5: 16'd3840, p6: 16'd5120,
		r_low:   RECIP_W'((RECIP_NUMER + 64'd767) / 64'd768),
		r_mrise: RECIP_W'((RECIP_NUMER + 64'd2354) / 64'd2355),
		r_mfall: RECIP_W'((RECIP_NUMER + 64'd1842) / 64'd1843),
		r_high:  RECIP_W'((RECIP_NUMER + 64'd1279) / 64'd1280)
	};

	// Result classes; on a tie the lowest code wins.
	typedef enum logic [1:0] {
		CLS_LISTENING    = 2'd0,
		CLS_UNIDENTIFIED = 2'd1,
		CLS_SOUNDS_LIKE  = 2'd2,
		CLS_IDENTIFIED   = 2'd3
	} class_t;

endpackage

// ----- rtl/fuzzy_match_result_classifier.sv -----
// ----------------------------------------------------------------------------
// Fuzzy match result classifier: top level
// Max-min fuzzy inference over confidence and duration grades into a class.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (confidence, duration) are written like a queue: a word is
//   taken at a clock edge with push high and full low. Results are read the
//   same way: class_label holds the oldest result while empty is low, and it
//   is consumed at an edge with pop high.
//   strict_mode_we writes strict_mode (easy or strict breakpoints); write it
//   only while no word is in flight.
//   A word passes through the two grading stages, one queue slot and the
//   result register before its result shows.
//   Throughput: one word per cycle while full stays low, set by the
//   two-stage grading pipeline with one reciprocal multiply per grade.
//   When the reader stalls, the result register holds, the grade queue fills
//   up to QUEUE_DEPTH words, the grading stages hold, and then full rises.
//   Reset clears all valid flags and the queue, and selects easy mode.
// ----------------------------------------------------------------------------
module fuzzy_match_result_classifier #(
	parameter int QUEUE_DEPTH = fmrc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        strict_mode_we,
	input  logic        strict_mode,
	input  logic        push,
	output logic        full,
	input  logic [15:0] confidence,
	input  logic [15:0] duration,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  class_label
);

	logic              strict_mode_q;
	logic              fe_valid;
	fmrc_pkg::grades_t fe_grades;
	logic              fe_ready;
	logic              be_valid;
	fmrc_pkg::grades_t be_grades;
	logic              be_ready;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_mode_q <= 1'b0;
		end else if (strict_mode_we) begin
			strict_mode_q <= strict_mode;
		end
	end

	fmrc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.strict_mode (strict_mode_q),
		.push        (push),
		.full        (full),
		.confidence  (confidence),
		.duration    (duration),
		.out_valid   (fe_valid),
		.out_grades  (fe_grades),
		.out_ready   (fe_ready)
	);

	fmrc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fe_valid),
		.wr_data  (fe_grades),
		.wr_ready (fe_ready),
		.rd_valid (be_valid),
		.rd_data  (be_grades),
		.rd_ready (be_ready)
	);

	fmrc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (be_valid),
		.in_grades   (be_grades),
		.in_ready    (be_ready),
		.empty       (empty),
		.pop         (pop),
		.class_label (class_label)
	);

endmodule

// ----- rtl/fmrc_front.sv -----
// ----------------------------------------------------------------------------
// Fuzzy match result classifier: grading front end
// Two-stage pipeline that turns confidence and duration into six grades.
// ----------------------------------------------------------------------------
module fmrc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                strict_mode,
	input  logic                push,
	output logic                full,
	input  logic [15:0]         confidence,
	input  logic [15:0]         duration,
	output logic                out_valid,
	output fmrc_pkg::grades_t   out_grades,
	input  logic                out_ready
);

	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_ONE,
		KIND_RAMP
	} kind_t;

	// One grade before the division: a fixed value or a ramp numerator and reciprocal.
	typedef struct packed {
		kind_t                              kind;
		logic [fmrc_pkg::NUM_W-1:0]         num;
		logic [fmrc_pkg::RECIP_W-1:0]       recip;
	} prep_t;

	function automatic prep_t prep_low(input logic [15:0] x, input fmrc_pkg::shape_t s);
		prep_t p;
		p.kind  = KIND_RAMP;
		p.num   = fmrc_pkg::NUM_W'(s.p1 - x);
		p.recip = s.r_low;
		if (x <= s.p0) begin
			p.kind = KIND_ONE;
		end else if (x >= s.p1) begin
			p.kind = KIND_ZERO;
		end
		return p;
	endfunction

	function automatic prep_t prep_med(input logic [15:0] x, input fmrc_pkg::shape_t s);
		prep_t p;
		p.kind = KIND_RAMP;
		if (x <= s.p3) begin
			p.num   = fmrc_pkg::NUM_W'(x - s.p2);
			p.recip = s.r_mrise;
			if (x <= s.p2) begin
				p.kind = KIND_ZERO;
			end
		end else begin
			p.num   = fmrc_pkg::NUM_W'(s.p4 - x);
			p.recip = s.r_mfall;
			if (x >= s.p4) begin
				p.kind = KIND_ZERO;
			end
		end
		return p;
	endfunction

	function automatic prep_t prep_high(input logic [15:0] x, input fmrc_pkg::shape_t s);
		prep_t p;
		p.kind  = KIND_RAMP;
		p.num   = fmrc_pkg::NUM_W'(x - s.p5);
		p.recip = s.r_high;
		if (x >= s.p6) begin
			p.kind = KIND_ONE;
		end else if (x <= s.p5) begin
			p.kind = KIND_ZERO;
		end
		return p;
	endfunction

	// Division by a constant segment width as a multiply by its reciprocal.
	function automatic fmrc_pkg::grade_t grade_of(input prep_t p);
		logic [fmrc_pkg::NUM_W+fmrc_pkg::RECIP_W-1:0] prod;
		fmrc_pkg::grade_t g;
		prod = (fmrc_pkg::NUM_W+fmrc_pkg::RECIP_W)'(p.num)
			* (fmrc_pkg::NUM_W+fmrc_pkg::RECIP_W)'(p.recip);
		case (p.kind)
			KIND_ONE:  g = fmrc_pkg::GRADE_ONE;
			KIND_RAMP: g = prod[fmrc_pkg::RECIP_SHIFT+fmrc_pkg::GRADE_W-1:fmrc_pkg::RECIP_SHIFT];
			default:   g = '0;
		endcase
		return g;
	endfunction

	fmrc_pkg::shape_t shape_c;
	fmrc_pkg::shape_t shape_d;
	logic             ready_s1;
	logic             ready_s2;
	logic             valid_s1;
	prep_t            cl_s1, cm_s1, ch_s1, ds_s1, dm_s1, dl_s1;
	logic             valid_s2;
	fmrc_pkg::grades_t grades_s2;

	// Stall chain: a stage takes a word when it is empty or moving on.
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign full     = !ready_s1;

	// Breakpoint set for the current mode.
	always_comb begin
		shape_c = strict_mode ? fmrc_pkg::CONF_STRICT : fmrc_pkg::CONF_EASY;
		shape_d = strict_mode ? fmrc_pkg::DUR_STRICT : fmrc_pkg::DUR_EASY;
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= push;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage 1: segment selection, numerators and reciprocals.
	always_ff @(posedge clk) begin
		if (push && ready_s1) begin
			cl_s1 <= prep_low(confidence, shape_c);
			cm_s1 <= prep_med(confidence, shape_c);
			ch_s1 <= prep_high(confidence, shape_c);
			ds_s1 <= prep_low(duration, shape_d);
			dm_s1 <= prep_med(duration, shape_d);
			dl_s1 <= prep_high(duration, shape_d);
		end
	end

	// Stage 2: reciprocal multiplies give the Q0.12 grades.
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			grades_s2.c_low   <= grade_of(cl_s1);
			grades_s2.c_med   <= grade_of(cm_s1);
			grades_s2.c_high  <= grade_of(ch_s1);
			grades_s2.d_short <= grade_of(ds_s1);
			grades_s2.d_med   <= grade_of(dm_s1);
			grades_s2.d_long  <= grade_of(dl_s1);
		end
	end

	assign out_valid  = valid_s2;
	assign out_grades = grades_s2;

endmodule

// ----- rtl/fmrc_queue.sv -----
// ----------------------------------------------------------------------------
// Fuzzy match result classifier: grade queue
// Small first-in first-out buffer between the grading and rule stages.
// ----------------------------------------------------------------------------
`include "fuzzy_match_result_classifier_macros.svh"

module fmrc_queue #(
	parameter int DEPTH = fmrc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	input  fmrc_pkg::grades_t wr_data,
	output logic              wr_ready,
	output logic              rd_valid,
	output fmrc_pkg::grades_t rd_data,
	input  logic              rd_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	fmrc_pkg::grades_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              wr_fire;
	logic              rd_fire;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign wr_fire  = wr_valid && wr_ready;
	assign rd_fire  = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_fire && !rd_fire) begin
				count_q <= count_q + 1'b1;
			end else if (rd_fire && !wr_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`FMRC_ASSERT_NOW(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "queue count over depth")
	`FMRC_ASSERT_NEXT(a_count_up, clk, arst_n, wr_fire && !rd_fire, count_q == CNT_W'($past(count_q) + 1'b1), "queue count did not rise on write")
	`FMRC_ASSERT_NEXT(a_count_down, clk, arst_n, rd_fire && !wr_fire, count_q == CNT_W'($past(count_q) - 1'b1), "queue count did not fall on read")
	`FMRC_ASSERT_NEXT(a_count_hold, clk, arst_n, rd_fire && wr_fire, $stable(count_q), "queue count moved on write with read")

endmodule

// ----- rtl/fmrc_back.sv -----
// ----------------------------------------------------------------------------
// Fuzzy match result classifier: rule evaluation back end
// Max-min rules, argmax over the four classes and the result register.
// ----------------------------------------------------------------------------
module fmrc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  fmrc_pkg::grades_t in_grades,
	output logic              in_ready,
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        class_label
);

	function automatic fmrc_pkg::grade_t gmin(input fmrc_pkg::grade_t a, input fmrc_pkg::grade_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic fmrc_pkg::grade_t gmax(input fmrc_pkg::grade_t a, input fmrc_pkg::grade_t b);
		return (a > b) ? a : b;
	endfunction

	fmrc_pkg::grade_t g_listen;
	fmrc_pkg::grade_t g_unid;
	fmrc_pkg::grade_t g_sounds;
	fmrc_pkg::grade_t g_ident;
	fmrc_pkg::grade_t best_g;
	fmrc_pkg::class_t best;
	fmrc_pkg::class_t class_q;
	logic             valid_q;

	// The result register frees up when it is empty or being read.
	assign in_ready = !valid_q || pop;

	// Rule strengths per class.
	always_comb begin
		g_listen = gmax(gmax(gmax(gmin(in_grades.c_high, in_grades.d_short),
		                          gmin(in_grades.c_med, in_grades.d_short)),
		                     gmax(gmin(in_grades.c_med, in_grades.d_med),
		                          gmin(in_grades.c_low, in_grades.d_short))),
		                gmin(in_grades.c_low, in_grades.d_med));
		g_unid   = gmin(in_grades.c_low, in_grades.d_long);
		g_sounds = gmin(in_grades.c_med, in_grades.d_long);
		g_ident  = gmax(gmin(in_grades.c_high, in_grades.d_med),
		                gmin(in_grades.c_high, in_grades.d_long));
	end

	// Argmax; only a strictly larger grade displaces a lower class.
	always_comb begin
		best   = fmrc_pkg::CLS_LISTENING;
		best_g = g_listen;
		if (g_unid > best_g) begin
			best   = fmrc_pkg::CLS_UNIDENTIFIED;
			best_g = g_unid;
		end
		if (g_sounds > best_g) begin
			best   = fmrc_pkg::CLS_SOUNDS_LIKE;
			best_g = g_sounds;
		end
		if (g_ident > best_g) begin
			best = fmrc_pkg::CLS_IDENTIFIED;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			class_q <= best;
		end
	end

	assign empty       = !valid_q;
	assign class_label = class_q;

endmodule

// ----- verif/fmrc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fuzzy match result classifier: scoreboard
// Watches the input and result queues of the classifier and tracks the mode
// register. For every word taken in, it works out the class that max-min
// inference gives, and it compares each result read out against the oldest
// class still owed.
// ----------------------------------------------------------------------------
module fmrc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        strict_mode_we,
	input  logic        strict_mode,
	input  logic        push,
	input  logic        full,
	input  logic [15:0] confidence,
	input  logic [15:0] duration,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  class_label,
	output int          fail_count,
	output int          waiting
);

	localparam int unsigned FULL_GRADE = 4096;

	// Corner points of the three trapezoids over one input.
	typedef struct packed {
		logic [15:0] lo_flat;
		logic [15:0] lo_end;
		logic [15:0] md_start;
		logic [15:0] md_peak;
		logic [15:0] md_end;
		logic [15:0] hi_start;
		logic [15:0] hi_flat;
	} knees_t;

	// Low, medium and high membership of one input, Q0.12.
	typedef struct packed {
		logic [12:0] lo;
		logic [12:0] md;
		logic [12:0] hi;
	} trio_t;

	fmrc_pkg::class_t owed_q[$];
	fmrc_pkg::class_t want;
	logic             mode_strict = 1'b0;
	int               mismatches = 0;
	int               outstanding = 0;

	assign fail_count = mismatches;
	assign waiting    = outstanding;

	function automatic knees_t confidence_knees(input logic strict);
		if (strict) begin
			return knees_t'{16'd9011, 16'd10650, 16'd9830, 16'd11469, 16'd15073,
				16'd14336, 16'd15565};
		end
		return knees_t'{16'd9011, 16'd10650, 16'd9830, 16'd11469, 16'd13107,
			16'd12288, 16'd14746};
	endfunction

	function automatic knees_t duration_knees(input logic strict);
		if (strict) begin
			return knees_t'{16'd512, 16'd1280, 16'd717, 16'd3072, 16'd4915,
				16'd3840, 16'd5120};
		end
		return knees_t'{16'd384, 16'd768, 16'd512, 16'd2560, 16'd5632,
			16'd4480, 16'd5120};
	endfunction

	// Rising slope: zero at or below a, full at b, truncated in between.
	function automatic int unsigned rise_grade(input int unsigned x, a, b);
		int unsigned span;
		int unsigned reach;
		span = b - a;
		if (x <= a) return 0;
		reach = x - a;
		if (reach > span) reach = span;
		return (reach * FULL_GRADE) / span;
	endfunction

	// Falling slope: full at a, zero at or above b.
	function automatic int unsigned fall_grade(input int unsigned x, a, b);
		int unsigned span;
		int unsigned reach;
		span = b - a;
		if (x >= b) return 0;
		reach = b - x;
		if (reach > span) reach = span;
		return (reach * FULL_GRADE) / span;
	endfunction

	function automatic trio_t grade_trio(input int unsigned x, input knees_t k);
		trio_t g;
		g.lo = 13'((x <= k.lo_flat) ? FULL_GRADE : fall_grade(x, k.lo_flat, k.lo_end));
		// The medium peak itself belongs to the rising side.
		g.md = 13'((x <= k.md_peak) ? rise_grade(x, k.md_start, k.md_peak)
			: fall_grade(x, k.md_peak, k.md_end));
		g.hi = 13'((x < k.hi_flat) ? rise_grade(x, k.hi_start, k.hi_flat) : FULL_GRADE);
		return g;
	endfunction

	function automatic int unsigned lesser(input int unsigned a, b);
		return (a < b) ? a : b;
	endfunction

	function automatic int unsigned greater(input int unsigned a, b);
		return (a > b) ? a : b;
	endfunction

	// Nine min rules, a max per class, then the first class with the top score.
	function automatic fmrc_pkg::class_t classify_word(input logic [15:0] conf, dur,
		input logic strict);
		trio_t            c;
		trio_t            d;
		int unsigned      score [4];
		fmrc_pkg::class_t best;
		int unsigned      best_score;
		c = grade_trio(conf, confidence_knees(strict));
		d = grade_trio(dur, duration_knees(strict));
		score[fmrc_pkg::CLS_LISTENING] = greater(greater(greater(lesser(c.hi, d.lo),
			lesser(c.md, d.lo)), greater(lesser(c.md, d.md), lesser(c.lo, d.lo))),
			lesser(c.lo, d.md));
		score[fmrc_pkg::CLS_UNIDENTIFIED] = lesser(c.lo, d.hi);
		score[fmrc_pkg::CLS_SOUNDS_LIKE]  = lesser(c.md, d.hi);
		score[fmrc_pkg::CLS_IDENTIFIED]   = greater(lesser(c.hi, d.md), lesser(c.hi, d.hi));
		best = fmrc_pkg::CLS_LISTENING;
		best_score = score[fmrc_pkg::CLS_LISTENING];
		for (int k = 1; k < 4; k++) begin
			if (score[k] > best_score) begin
				best = fmrc_pkg::class_t'(k);
				best_score = score[k];
			end
		end
		return best;
	endfunction

	// Results are matched before new words are queued; a word can never
	// come out at the edge that takes it in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_strict <= 1'b0;
			owed_q.delete();
			outstanding <= 0;
		end else begin
			if (pop && !empty) begin
				if (owed_q.size() == 0) begin
					$error("class_label: expected nothing, actual %0d", class_label);
					mismatches++;
				end else begin
					want = owed_q.pop_front();
					if (class_label !== want) begin
						$error("class_label: expected %0d, actual %0d", want, class_label);
						mismatches++;
					end
				end
			end
			if (push && !full) begin
				owed_q.push_back(classify_word(confidence, duration, mode_strict));
			end
			if (strict_mode_we) begin
				mode_strict <= strict_mode;
			end
			outstanding <= owed_q.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fuzzy match result classifier: testbench top
// Drives words through the classifier in both modes: a directed set of corner
// and tie words, then random words clustered around the trapezoid corners,
// with random gaps on the writer and random stalls on the reader. The
// scoreboard beside the block checks every result.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_WORDS  = 100;
	localparam int SETTLE_TICKS = 8;

	localparam logic [15:0] CORNER_CONF [12] = '{
		16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd11469, 16'd11469,
		16'hFFFF, 16'd10240, 16'd9011, 16'd10650, 16'd13107, 16'd14746
	};
	localparam logic [15:0] CORNER_DUR [12] = '{
		16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd2560,
		16'd2560, 16'hFFFF, 16'd384, 16'd768, 16'd5632, 16'd5120
	};
	localparam int CONF_KNEES [10] = '{
		9011, 10650, 9830, 11469, 13107, 12288, 14746, 15073, 14336, 15565
	};
	localparam int DUR_KNEES [12] = '{
		384, 768, 512, 2560, 5632, 4480, 5120, 1280, 717, 3072, 4915, 3840
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        strict_mode_we = 1'b0;
	logic        strict_mode = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [15:0] confidence = 16'd0;
	logic [15:0] duration = 16'd0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  class_label;
	logic        calm = 1'b0;
	int          fail_count;
	int          waiting;
	int          cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	fuzzy_match_result_classifier u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.strict_mode_we (strict_mode_we),
		.strict_mode    (strict_mode),
		.push           (push),
		.full           (full),
		.confidence     (confidence),
		.duration       (duration),
		.empty          (empty),
		.pop            (pop),
		.class_label    (class_label)
	);

	fmrc_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.strict_mode_we (strict_mode_we),
		.strict_mode    (strict_mode),
		.push           (push),
		.full           (full),
		.confidence     (confidence),
		.duration       (duration),
		.empty          (empty),
		.pop            (pop),
		.class_label    (class_label),
		.fail_count     (fail_count),
		.waiting        (waiting)
	);

	// The reader stalls now and then, except during the calm stretch.
	always @(posedge clk) begin
		pop <= calm ? 1'b1 : ($urandom_range(99) >= 14);
	end

	// Hard stop in case the block hangs.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// A value a little either side of a corner point.
	function automatic logic [15:0] near_knee(input int knee);
		int v;
		v = knee + int'($urandom_range(64)) - 32;
		if (v < 0) v = 0;
		return 16'(v);
	endfunction

	function automatic logic [15:0] pick_confidence();
		int r;
		r = $urandom_range(99);
		if (r < 55) return near_knee(CONF_KNEES[$urandom_range(9)]);
		if (r < 80) return 16'($urandom_range(17000));
		return 16'($urandom_range(65535));
	endfunction

	function automatic logic [15:0] pick_duration();
		int r;
		r = $urandom_range(99);
		if (r < 55) return near_knee(DUR_KNEES[$urandom_range(11)]);
		if (r < 80) return 16'($urandom_range(6000));
		return 16'($urandom_range(65535));
	endfunction

	// Offer one word and hold it until the block takes it.
	task automatic send_word(input logic [15:0] conf, input logic [15:0] dur);
		while (!calm && $urandom_range(99) < 14) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		confidence <= conf;
		duration <= dur;
		do @(posedge clk); while (full);
	endtask

	// Stop writing and wait until every owed result has been read.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
	endtask

	// Mode changes happen only with the pipeline empty.
	task automatic set_mode(input logic strict);
		drain();
		repeat (4) @(posedge clk);
		strict_mode_we <= 1'b1;
		strict_mode <= strict;
		@(posedge clk);
		strict_mode_we <= 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corners, crossings and a low/medium tie, first in easy mode after
		// reset, then in strict mode.
		for (int m = 0; m < 2; m++) begin
			if (m == 1) set_mode(1'b1);
			for (int i = 0; i < 12; i++) begin
				send_word(CORNER_CONF[i], CORNER_DUR[i]);
			end
		end

		// Random phases alternate the mode; the third runs with no idling.
		for (int phase = 0; phase < 4; phase++) begin
			set_mode(phase[0]);
			calm <= (phase == 2);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				send_word(pick_confidence(), pick_duration());
			end
		end

		drain();
		calm <= 1'b0;
		repeat (SETTLE_TICKS) @(posedge clk);
		if (fail_count == 0 && waiting == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- fuzzy_match_result_classifier.f -----
+incdir+rtl
rtl/fmrc_pkg.sv
rtl/fmrc_front.sv
rtl/fmrc_queue.sv
rtl/fmrc_back.sv
rtl/fuzzy_match_result_classifier.sv
verif/fmrc_checker.sv
verif/tb.sv
